// File: hw/rtl/awms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awms_pkg
// Shared types and constants for the adaptive weighted move selector.
// ----------------------------------------------------------------------------
package awms_pkg;

  localparam int unsigned WeightWidth = 17;
  localparam int unsigned RandWidth   = 16;
  localparam int unsigned KindWidth   = 4;
  localparam int unsigned OpWidth     = 2;
  localparam int unsigned RegWidth    = 16;
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [WeightWidth-1:0] WeightMax   = 17'd131071;
  localparam logic [WeightWidth-1:0] WeightReset = 17'd16384;
  localparam logic [16:0]            Band        = 17'd6554;
  localparam logic [KindWidth-1:0]   FallbackKind = 4'd2;

  typedef enum logic [OpWidth-1:0] {
    OP_SELECT = 2'd0,
    OP_RECORD = 2'd1,
    OP_SETW   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_ADAPT_EN   = 3'd0,
    REG_SEL_MODE   = 3'd1,
    REG_TARGET     = 3'd2,
    REG_ADAPT_RATE = 3'd3,
    REG_INTERVAL   = 3'd4
  } reg_e;

  // Command broadcast from the sequencer to every cell.
  typedef enum logic [3:0] {
    CMD_NONE   = 4'd0,
    CMD_CLEAR  = 4'd1,
    CMD_RECORD = 4'd2,
    CMD_SETW   = 4'd3,
    CMD_SCALE  = 4'd4,
    CMD_NORM   = 4'd5,
    CMD_ROT    = 4'd6
  } cmd_e;

  typedef struct packed {
    cmd_e                   cmd;
    logic [KindWidth-1:0]   kind;
    logic                   acc;
    logic [WeightWidth-1:0] wval;
  } cell_ctrl_t;

endpackage : awms_pkg
`default_nettype wire

// File: hw/rtl/awms_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awms_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface awms_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : awms_if
`default_nettype wire

// File: hw/rtl/awms_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awms_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module awms_divider #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 48,
  parameter int unsigned QW   = 17
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [QW-1:0]        quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], num_q[NumW-1]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = QW'(quo_q);
endmodule : awms_divider
`default_nettype wire

// File: hw/rtl/awms_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awms_cell
// One move type: weight and counters. Cells form a ring that rotates by one
// position on CMD_ROT; the head cell is seen by the shared sequencer.
// ----------------------------------------------------------------------------
module awms_cell #(
  parameter int unsigned CountWidth = 32,
  parameter logic [3:0]  Index      = 4'd0
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  awms_pkg::cell_ctrl_t                     ctrl_i,
  input  wire logic                                head_i,
  input  wire logic [awms_pkg::WeightWidth-1:0]    head_w_i,
  input  wire logic [awms_pkg::WeightWidth-1:0]    prev_w_i,
  input  wire logic [CountWidth-1:0]               prev_att_i,
  input  wire logic [CountWidth-1:0]               prev_acc_i,
  input  wire logic [3:0]                          prev_id_i,
  output logic [awms_pkg::WeightWidth-1:0]         w_o,
  output logic [CountWidth-1:0]                    att_o,
  output logic [CountWidth-1:0]                    acc_o,
  output logic [3:0]                               id_o
);
  import awms_pkg::*;

  logic [WeightWidth-1:0] w_q, w_d;
  logic [CountWidth-1:0]  att_q, att_d, acc_q, acc_d;
  logic [3:0]             id_q, id_d;
  logic                   mine;

  assign mine = (ctrl_i.kind == id_q);

  always_comb begin
    w_d   = w_q;
    att_d = att_q;
    acc_d = acc_q;
    id_d  = id_q;
    case (ctrl_i.cmd)
      CMD_CLEAR: begin
        att_d = '0;
        acc_d = '0;
      end
      CMD_RECORD: begin
        if (mine) begin
          if (att_q != '1) att_d = att_q + 1'b1;
          if (ctrl_i.acc && acc_q != '1) acc_d = acc_q + 1'b1;
        end
      end
      CMD_SETW: if (mine) w_d = ctrl_i.wval;
      CMD_SCALE, CMD_NORM: if (head_i) w_d = head_w_i;
      CMD_ROT: begin
        w_d   = prev_w_i;
        att_d = prev_att_i;
        acc_d = prev_acc_i;
        id_d  = prev_id_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= (Index < 4'd4) ? WeightReset : '0;
      att_q <= '0;
      acc_q <= '0;
      id_q  <= Index;
    end else begin
      w_q   <= w_d;
      att_q <= att_d;
      acc_q <= acc_d;
      id_q  <= id_d;
    end
  end

  assign w_o   = w_q;
  assign att_o = att_q;
  assign acc_o = acc_q;
  assign id_o  = id_q;
endmodule : awms_cell
`default_nettype wire

// File: hw/rtl/adaptive_weighted_move_selector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_weighted_move_selector
// Roulette-wheel move selection over a ring of per-type cells with
// acceptance-rate adaptation and renormalization.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_ch    in   operation, move_kind, accepted_flag, weight_value, random_value
// out_ch   out  chosen_move, adapted
// cfg_ch   in   index, value
//
// One item at a time. Record without a pass, clear, ignored kinds: straight
// to S_OUT. Plain select: one ring rotation; weighted select: two (total,
// compare). Set weight: one rotation to sum, then a divide per type to
// renormalize. Adaptation pass: a rate divide per type of nonzero weight
// with over 10 attempts, then as set weight. Reset is asynchronous; a
// pending result blocks the input until taken.
// ----------------------------------------------------------------------------
module adaptive_weighted_move_selector #(
  parameter int unsigned NUM_MOVE_TYPES = 9,
  parameter int unsigned COUNT_WIDTH    = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  awms_if.sink      in_ch,
  awms_if.source    out_ch,
  awms_if.sink      cfg_ch
);
  import awms_pkg::*;

  localparam int unsigned N   = NUM_MOVE_TYPES;
  localparam int unsigned CW  = COUNT_WIDTH;
  localparam int unsigned TW  = WeightWidth + 4;   // sum of effective weights
  localparam int unsigned PW  = CW + 16;           // Q16 numerator for rate

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SEL   = 8'b0000_0010,
    S_TOT   = 8'b0000_0100,
    S_SCALE = 8'b0000_1000,
    S_SUM   = 8'b0001_0000,
    S_NORM  = 8'b0010_0000,
    S_DIVW  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Config registers
  logic        aen_q, smode_q;
  logic [15:0] tgt_q, arate_q, intv_q, osa_q, osa_d;

  // Latched item
  logic [1:0]             op_q;
  logic [KindWidth-1:0]   kind_q;
  logic                   accf_q;
  logic [WeightWidth-1:0] wv_q;
  logic [RandWidth-1:0]   rnd_q;

  // Work registers
  logic [3:0]             step_q, step_d;
  logic [TW-1:0]          cum_q, cum_d, tot_q, tot_d;
  logic                   found_q, found_d;
  logic [KindWidth-1:0]   pick_q, pick_d;
  logic                   pass_q, pass_d;  // set when an adaptation pass runs
  logic                   divwait_q, divwait_d;
  logic [1:0]             sph_q, sph_d;    // scale sub-phase
  logic [PW-1:0]          prod_q, prod_d;
  logic                   out_v_q;
  logic [KindWidth-1:0]   out_k_q;
  logic                   out_a_q;

  cell_ctrl_t             ctrl;
  logic [WeightWidth-1:0] head_w;

  logic [WeightWidth-1:0] w   [N];
  logic [CW-1:0]          att [N];
  logic [CW-1:0]          acc [N];
  logic [3:0]             id  [N];

  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam int unsigned P = (g + 1) % N;
    awms_cell #(.CountWidth(CW), .Index(4'(g))) u_cell (
      .clk_i, .rst_ni,
      .ctrl_i    (ctrl),
      .head_i    (g == 0),
      .head_w_i  (head_w),
      .prev_w_i  (w[P]),
      .prev_att_i(att[P]),
      .prev_acc_i(acc[P]),
      .prev_id_i (id[P]),
      .w_o       (w[g]),
      .att_o     (att[g]),
      .acc_o     (acc[g]),
      .id_o      (id[g])
    );
  end

  // Head cell views
  logic [CW-1:0] hatt, hacc;
  logic [WeightWidth-1:0] hw;
  assign hatt = att[0];
  assign hacc = acc[0];
  assign hw   = w[0];

  // Effective weight of the head cell
  logic [WeightWidth:0] eff;
  logic [CW+3:0]        acc10;
  logic [CW:0]          acc2;
  always_comb begin
    acc10 = {hacc, 3'b000} + {3'b000, hacc, 1'b0};
    acc2  = {hacc, 1'b0};
    eff   = {1'b0, hw};
    if (hatt >= CW'(10)) begin
      if (acc10 < (CW+4)'(hatt))      eff = {hw, 1'b0};
      else if (acc2 > (CW+1)'(hatt))  eff = {2'b00, hw[WeightWidth-1:1]};
    end
  end

  // Shared divider
  logic          div_start, div_done;
  logic [PW-1:0] div_num;
  logic [PW-1:0] div_den;
  logic [PW-1:0] div_quo;
  awms_divider #(.NumW(PW), .DenW(PW), .QW(PW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quo)
  );

  // Weighted compare: rnd*T <= cum*65536
  logic [TW+15:0] lhs, rhs;
  logic [TW-1:0]  cum_n;
  assign cum_n = cum_q + TW'(eff);
  assign lhs   = TW'(rnd_q) * tot_q;
  assign rhs   = {cum_n, 16'h0};

  logic [16:0] lo_s, hi_s;
  logic        lo_neg;
  assign lo_neg = ({1'b0, tgt_q} < Band);
  assign lo_s   = {1'b0, tgt_q} - Band;
  assign hi_s   = {1'b0, tgt_q} + Band;

  logic [WeightWidth+16:0] sprod;
  logic [16:0]             sfac;

  logic in_fire, out_fire;
  logic kind_ok;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign kind_ok  = ({1'b0, in_ch.data.move_kind} < (KindWidth+1)'(N));
  assign in_ch.ready  = (state_q == S_IDLE) && !out_v_q;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    cum_d     = cum_q;
    tot_d     = tot_q;
    found_d   = found_q;
    pick_d    = pick_q;
    pass_d    = pass_q;
    divwait_d = divwait_q;
    sph_d     = sph_q;
    prod_d    = prod_q;
    osa_d     = osa_q;
    ctrl      = '{cmd: CMD_NONE, kind: kind_q, acc: accf_q, wval: wv_q};
    head_w    = hw;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sfac      = 17'h10000 - {1'b0, arate_q};
    sprod     = '0;
    case (state_q)
      S_IDLE: begin
        step_d  = '0;
        cum_d   = '0;
        tot_d   = '0;
        found_d = 1'b0;
        pick_d  = FallbackKind;
        pass_d  = 1'b0;
        sph_d   = '0;
        if (in_fire) begin
          case (op_e'(in_ch.data.operation))
            OP_SELECT: state_d = smode_q ? S_TOT : S_SEL;
            OP_RECORD: begin
              if (kind_ok) begin
                ctrl = '{cmd: CMD_RECORD, kind: in_ch.data.move_kind,
                         acc: in_ch.data.accepted_flag, wval: '0};
                if (osa_q != 16'hFFFF) osa_d = osa_q + 1'b1;
                if (aen_q && ((osa_q != 16'hFFFF ? osa_q + 1'b1 : osa_q) >= intv_q)) begin
                  osa_d  = '0;
                  pass_d = 1'b1;
                  state_d = S_SCALE;
                end else begin
                  state_d = S_OUT;
                end
              end else begin
                state_d = S_OUT;
              end
            end
            OP_SETW: begin
              if (kind_ok) begin
                ctrl = '{cmd: CMD_SETW, kind: in_ch.data.move_kind, acc: 1'b0,
                         wval: in_ch.data.weight_value};
                state_d = S_SUM;
              end else begin
                state_d = S_OUT;
              end
            end
            default: begin
              ctrl    = '{cmd: CMD_CLEAR, kind: '0, acc: 1'b0, wval: '0};
              osa_d   = '0;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_SEL: begin
        // plain: walk ring, first cum >= r
        cum_d = cum_q + TW'(hw);
        if (!found_q && ({{(TW-RandWidth){1'b0}}, rnd_q} <= cum_q + TW'(hw))) begin
          found_d = 1'b1;
          pick_d  = id[0];
        end
        ctrl.cmd = CMD_ROT;
        step_d   = step_q + 1'b1;
        if (step_q == 4'(N - 1)) state_d = S_OUT;
      end
      S_TOT: begin
        // two rotations: sph 0 sums T, sph 1 compares
        ctrl.cmd = CMD_ROT;
        step_d   = step_q + 1'b1;
        if (sph_q == 2'd0) begin
          if (hw != '0) tot_d = tot_q + TW'(eff);
          if (step_q == 4'(N - 1)) begin
            step_d = '0;
            sph_d  = 2'd1;
          end
        end else begin
          if (hw != '0) begin
            cum_d = cum_n;
            if (!found_q && lhs <= rhs) begin
              found_d = 1'b1;
              pick_d  = id[0];
            end
          end
          if (step_q == 4'(N - 1)) state_d = S_OUT;
        end
      end
      S_SCALE: begin
        // per head: rate division, then multiply, then rotate; zero weight or <= 10 attempts: rotate only
        case (sph_q)
          2'd0: begin
            if (hw == '0 || hatt <= CW'(10)) begin
              ctrl.cmd = CMD_ROT;
              step_d   = step_q + 1'b1;
              if (step_q == 4'(N - 1)) begin
                step_d  = '0;
                state_d = S_SUM;
              end
            end else begin
              div_start = 1'b1;
              div_num   = {hacc, 16'h0};
              div_den   = PW'(hatt);
              sph_d     = 2'd1;
            end
          end
          2'd1: begin
            if (div_done) begin
              prod_d = div_quo;
              sph_d  = 2'd2;
            end
          end
          default: begin
            if (!lo_neg && prod_q < PW'(lo_s)) begin
              sfac  = 17'h10000 - {1'b0, arate_q};
              sprod = hw * sfac;
              ctrl.cmd = CMD_SCALE;
              head_w   = sprod[WeightWidth+15:16];
            end else if (prod_q > PW'(hi_s)) begin
              sfac  = 17'h10000 + {1'b0, arate_q};
              sprod = hw * sfac;
              ctrl.cmd = CMD_SCALE;
              head_w = (sprod[WeightWidth+16:16] > {1'b0, WeightMax}) ? WeightMax
                                                                      : sprod[WeightWidth+15:16];
            end
            sph_d = 2'd3;
            if (sph_q == 2'd3) begin
              ctrl.cmd = CMD_ROT;
              sph_d    = '0;
              step_d   = step_q + 1'b1;
              if (step_q == 4'(N - 1)) begin
                step_d  = '0;
                state_d = S_SUM;
              end
            end
          end
        endcase
      end
      S_SUM: begin
        ctrl.cmd = CMD_ROT;
        tot_d    = tot_q + TW'(hw);
        step_d   = step_q + 1'b1;
        if (step_q == 4'(N - 1)) begin
          step_d  = '0;
          state_d = (tot_q + TW'(hw) == '0) ? S_OUT : S_NORM;
        end
      end
      S_NORM: begin
        div_start = 1'b1;
        div_num   = PW'({hw, 16'h0});
        div_den   = PW'(tot_q);
        state_d   = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          ctrl.cmd = CMD_NORM;
          head_w   = WeightWidth'(div_quo);
          divwait_d = 1'b1;
        end
        if (divwait_q) begin
          divwait_d = 1'b0;
          ctrl.cmd  = CMD_ROT;
          step_d    = step_q + 1'b1;
          state_d   = (step_q == 4'(N - 1)) ? S_OUT : S_NORM;
        end
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      aen_q     <= 1'b0;
      smode_q   <= 1'b0;
      tgt_q     <= 16'd19661;
      arate_q   <= 16'd655;
      intv_q    <= 16'd1000;
      osa_q     <= '0;
      out_v_q   <= 1'b0;
      step_q    <= '0;
      found_q   <= 1'b0;
      pass_q    <= 1'b0;
      divwait_q <= 1'b0;
      sph_q     <= '0;
    end else begin
      state_q   <= state_d;
      osa_q     <= osa_d;
      step_q    <= step_d;
      found_q   <= found_d;
      pass_q    <= pass_d;
      divwait_q <= divwait_d;
      sph_q     <= sph_d;
      if (cfg_ch.valid) begin
        case (reg_e'(cfg_ch.data.index))
          REG_ADAPT_EN:   aen_q   <= cfg_ch.data.value[0];
          REG_SEL_MODE:   smode_q <= cfg_ch.data.value[0];
          REG_TARGET:     tgt_q   <= cfg_ch.data.value[15:0];
          REG_ADAPT_RATE: arate_q <= cfg_ch.data.value[15:0];
          REG_INTERVAL:   intv_q  <= cfg_ch.data.value[15:0];
          default: ;
        endcase
      end
      if (state_q == S_OUT) out_v_q <= 1'b1;
      else if (out_fire)    out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cum_q  <= cum_d;
    tot_q  <= tot_d;
    pick_q <= pick_d;
    prod_q <= prod_d;
    if (in_fire) begin
      op_q   <= in_ch.data.operation;
      kind_q <= in_ch.data.move_kind;
      accf_q <= in_ch.data.accepted_flag;
      wv_q   <= in_ch.data.weight_value;
      rnd_q  <= in_ch.data.random_value;
    end
    if (state_q == S_OUT) begin
      out_k_q <= (op_q == OP_SELECT) ? pick_q : '0;
      out_a_q <= pass_q;
    end
  end

  assign out_ch.valid            = out_v_q;
  assign out_ch.data.chosen_move = out_k_q;
  assign out_ch.data.adapted     = out_a_q;
endmodule : adaptive_weighted_move_selector
`default_nettype wire
